FILE: rtl/core/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Types and constants shared by the column path tokenizer.
// ----------------------------------------------------------------------------
package spt_pkg;

    typedef enum logic [2:0] {
        PH_START, PH_NAME, PH_OPENED, PH_UNQUOTED, PH_QUOTED, PH_CLOSE_STR, PH_CLOSE_ALL
    } phase_t;

    localparam logic [1:0] RK_CONTENT = 2'd0;
    localparam logic [1:0] RK_END     = 2'd1;
    localparam logic [1:0] RK_ERROR   = 2'd2;

    localparam logic [1:0] TK_NESTED = 2'd0;
    localparam logic [1:0] TK_INDEX  = 2'd1;
    localparam logic [1:0] TK_STRING = 2'd2;
    localparam logic [1:0] TK_ALL    = 2'd3;

    localparam logic [1:0] ERR_SYNTAX = 2'd0;
    localparam logic [1:0] ERR_UTF8   = 2'd1;
    localparam logic [1:0] ERR_INDEX  = 2'd2;
    localparam logic [1:0] ERR_UNTERM = 2'd3;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DOT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WILD   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 8'd5;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [1:0]         token_kind;
        logic [7:0]         content_byte;
        logic signed [63:0] index_value;
        logic [1:0]         error_code;
        logic               path_end;
        logic               run_last;
    } result_t;

    // All results caused by one path byte
    typedef struct packed {
        logic [1:0] count;
        result_t    res1;
        result_t    res0;
    } step_t;

endpackage

FILE: rtl/core/spt_front.sv
// ----------------------------------------------------------------------------
// spt_front
// Accepts path bytes, runs the tokenizer state and builds one step record.
// ----------------------------------------------------------------------------
module spt_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    path_byte,
    input  logic                          final_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output logic                          push_valid,
    input  logic                          push_ready,
    output spt_pkg::step_t                push_data
);
    import spt_pkg::*;

    logic [6:0] dot_reg, open_reg, close_reg, quote_reg, wild_reg, esc_reg;

    phase_t      phase_reg, phase_next;
    logic        first_reg, first_next;
    logic        escp_reg, escp_next;
    logic [1:0]  ulft_reg, ulft_next;
    logic [20:0] upart_reg, upart_next;
    logic        nonempty_reg, nonempty_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        seen_reg, seen_next;
    logic        stop_reg, stop_next;
    logic        ovf_reg, ovf_next;
    logic [1:0]  star_reg, star_next;
    logic        failed_reg, failed_next;

    logic        accept;
    result_t     res [2];
    logic [1:0]  n;

    function automatic logic is_sub(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "_" || c == "-";
    endfunction

    function automatic logic is_path(input logic [7:0] c);
        return c == ":" || c == "$" || c == "-" || c == "/" || c == "@" ||
               c == "|" || c == "#" || c == "." || is_sub(c);
    endfunction

    function automatic result_t mk(input logic [1:0] rk, input logic [1:0] tk,
                                   input logic [7:0] by, input logic [63:0] iv,
                                   input logic [1:0] er);
        result_t r;
        r.result_kind  = rk;
        r.token_kind   = tk;
        r.content_byte = by;
        r.index_value  = iv;
        r.error_code   = er;
        r.path_end     = 1'b0;
        r.run_last     = 1'b0;
        return r;
    endfunction

    assign cfg_ready  = 1'b1;
    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept && (n != 2'd0);

    always_comb
    begin
        logic        ok, take, asc, go, delim, first_c;
        logic [7:0]  b;
        logic [67:0] prod;
        logic [67:0] lim;
        b = path_byte;
        phase_next = phase_reg;   first_next = first_reg;  escp_next = escp_reg;
        ulft_next = ulft_reg;     upart_next = upart_reg;  nonempty_next = nonempty_reg;
        acc_next = acc_reg;       neg_next = neg_reg;      seen_next = seen_reg;
        stop_next = stop_reg;     ovf_next = ovf_reg;      star_next = star_reg;
        failed_next = failed_reg;
        res[0] = '0;
        res[1] = '0;
        n = 2'd0;
        take = 1'b0;
        asc = 1'b0;
        ok = 1'b0;
        go = 1'b0;
        first_c = 1'b0;
        prod = '0;
        lim = '0;
        delim = (b[7] == 1'b0) && (b[6:0] == dot_reg || b[6:0] == open_reg ||
                b[6:0] == close_reg || b[6:0] == quote_reg || b[6:0] == wild_reg);

        if (!failed_reg)
        begin
            if (ulft_reg != 2'd0)
            begin
                ok = (b[7:6] == 2'b10);
                if (ok && ulft_reg == 2'd3)
                begin
                    if ((upart_reg == 21'd0 && b < 8'h90) || (upart_reg == 21'd4 && b > 8'h8F))
                        ok = 1'b0;
                end
                else if (ok && ulft_reg == 2'd2 && upart_reg < 21'h10)
                begin
                    if ((upart_reg == 21'd0 && b < 8'hA0) || (upart_reg == 21'hD && b > 8'h9F))
                        ok = 1'b0;
                end
                if (!ok)
                begin
                    res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_UTF8);
                    n = n + 2'd1;
                    failed_next = 1'b1;
                end
                else
                begin
                    upart_next = {upart_reg[14:0], b[5:0]};
                    ulft_next = ulft_reg - 2'd1;
                    if (phase_reg == PH_NAME)
                    begin
                        res[n[0]] = mk(RK_CONTENT, TK_NESTED, b, 64'd0, ERR_SYNTAX);
                        n = n + 2'd1;
                    end
                    else if (phase_reg == PH_QUOTED)
                    begin
                        star_next = 2'd2;
                        res[n[0]] = mk(RK_CONTENT, TK_STRING, b, 64'd0, ERR_SYNTAX);
                        n = n + 2'd1;
                    end
                end
            end
            else if (b < 8'h80)
            begin
                take = 1'b1;
                asc = 1'b1;
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                ulft_next = 2'd1;
                upart_next = {16'd0, b[4:0]};
                take = 1'b1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                ulft_next = 2'd2;
                upart_next = {17'd0, b[3:0]};
                take = 1'b1;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                ulft_next = 2'd3;
                upart_next = {18'd0, b[2:0]};
                take = 1'b1;
            end
            else
            begin
                res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_UTF8);
                n = n + 2'd1;
                failed_next = 1'b1;
            end
        end

        go = take;
        for (int it = 0; it < 3; it++)
        begin
            if (go)
            begin
                go = 1'b0;
                case (phase_next)
                    PH_START:
                    begin
                        if (asc && b[6:0] == dot_reg)
                        begin
                            phase_next = PH_NAME;
                            nonempty_next = 1'b0;
                            first_next = 1'b0;
                        end
                        else if (asc && b[6:0] == open_reg)
                        begin
                            phase_next = PH_OPENED;
                            first_next = 1'b0;
                        end
                        else if (first_next)
                        begin
                            phase_next = PH_NAME;
                            nonempty_next = 1'b0;
                            first_next = 1'b0;
                            go = 1'b1;
                        end
                        else
                        begin
                            res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                            failed_next = 1'b1;
                        end
                    end
                    PH_NAME:
                    begin
                        if (!asc || (!delim && is_path(b)))
                        begin
                            nonempty_next = 1'b1;
                            res[n[0]] = mk(RK_CONTENT, TK_NESTED, b, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                        end
                        else if (!nonempty_next)
                        begin
                            res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            res[n[0]] = mk(RK_END, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                            phase_next = PH_START;
                            go = 1'b1;
                        end
                    end
                    PH_OPENED:
                    begin
                        if (asc && b[6:0] == quote_reg)
                        begin
                            phase_next = PH_QUOTED;
                            star_next = 2'd0;
                            escp_next = 1'b0;
                        end
                        else if (asc && b[6:0] == wild_reg)
                        begin
                            phase_next = PH_CLOSE_ALL;
                        end
                        else
                        begin
                            phase_next = PH_UNQUOTED;
                            nonempty_next = 1'b0;
                            acc_next = 64'd0;
                            neg_next = 1'b0;
                            seen_next = 1'b0;
                            stop_next = 1'b0;
                            ovf_next = 1'b0;
                            go = 1'b1;
                        end
                    end
                    PH_UNQUOTED:
                    begin
                        if (!asc || is_sub(b))
                        begin
                            first_c = !nonempty_next;
                            nonempty_next = 1'b1;
                            if (!stop_next)
                            begin
                                if (asc && b >= "0" && b <= "9")
                                begin
                                    // acc*10 + d against the signed limit, no divide needed
                                    prod = {4'd0, acc_next} * 68'd10 + {64'd0, b[3:0]};
                                    lim = neg_next ? 68'h0_8000_0000_0000_0000
                                                   : 68'h0_7FFF_FFFF_FFFF_FFFF;
                                    seen_next = 1'b1;
                                    if (!ovf_next)
                                    begin
                                        if (prod > lim)
                                            ovf_next = 1'b1;
                                        else
                                            acc_next = prod[63:0];
                                    end
                                end
                                else if (asc && b == "-" && first_c)
                                    neg_next = 1'b1;
                                else
                                    stop_next = 1'b1;
                            end
                        end
                        else if (!nonempty_next)
                        begin
                            res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                            failed_next = 1'b1;
                        end
                        else if (!seen_next || ovf_next)
                        begin
                            res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_INDEX);
                            n = n + 2'd1;
                            failed_next = 1'b1;
                        end
                        else if (b[6:0] == close_reg)
                        begin
                            res[n[0]] = mk(RK_END, TK_INDEX, 8'd0,
                                           neg_next ? (64'd0 - acc_next) : acc_next,
                                           ERR_SYNTAX);
                            n = n + 2'd1;
                            phase_next = PH_START;
                        end
                        else
                        begin
                            res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                            failed_next = 1'b1;
                        end
                    end
                    PH_QUOTED:
                    begin
                        if (escp_next)
                        begin
                            escp_next = 1'b0;
                            if (asc && (b[6:0] == quote_reg || b[6:0] == esc_reg))
                            begin
                                star_next = (star_next == 2'd0 && b == "*") ? 2'd1 : 2'd2;
                                res[n[0]] = mk(RK_CONTENT, TK_STRING, b, 64'd0, ERR_SYNTAX);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX);
                                n = n + 2'd1;
                                failed_next = 1'b1;
                            end
                        end
                        else if (asc && b[6:0] == esc_reg)
                            escp_next = 1'b1;
                        else if (asc && b[6:0] == quote_reg)
                            phase_next = (star_next == 2'd1) ? PH_CLOSE_ALL : PH_CLOSE_STR;
                        else
                        begin
                            star_next = (star_next == 2'd0 && asc && b == "*") ? 2'd1 : 2'd2;
                            res[n[0]] = mk(RK_CONTENT, TK_STRING, b, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                        end
                    end
                    PH_CLOSE_STR, PH_CLOSE_ALL:
                    begin
                        if (asc && b[6:0] == close_reg)
                        begin
                            res[n[0]] = mk(RK_END,
                                           (phase_next == PH_CLOSE_ALL) ? TK_ALL : TK_STRING,
                                           8'd0, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                            phase_next = PH_START;
                        end
                        else
                        begin
                            res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX);
                            n = n + 2'd1;
                            failed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX);
                        n = n + 2'd1;
                        failed_next = 1'b1;
                    end
                endcase
            end
        end

        if (final_byte)
        begin
            if (!failed_next)
            begin
                if (ulft_next != 2'd0)
                begin
                    res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_UTF8);
                    n = n + 2'd1;
                end
                else if (phase_next == PH_NAME)
                begin
                    res[n[0]] = nonempty_next ?
                                mk(RK_END, TK_NESTED, 8'd0, 64'd0, ERR_SYNTAX) :
                                mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_UNTERM);
                    n = n + 2'd1;
                end
                else if (phase_next == PH_UNQUOTED)
                begin
                    res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0,
                                   (nonempty_next && (!seen_next || ovf_next)) ?
                                   ERR_INDEX : ERR_UNTERM);
                    n = n + 2'd1;
                end
                else if (phase_next == PH_START)
                begin
                    if (n == 2'd0)
                    begin
                        res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_UNTERM);
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    res[n[0]] = mk(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ERR_UNTERM);
                    n = n + 2'd1;
                end
            end
            if (n == 2'd1)
                res[0].path_end = 1'b1;
            else if (n == 2'd2)
                res[1].path_end = 1'b1;
            // start over with a fresh path
            phase_next = PH_START;   first_next = 1'b1;  escp_next = 1'b0;
            ulft_next = 2'd0;        upart_next = 21'd0; nonempty_next = 1'b0;
            acc_next = 64'd0;        neg_next = 1'b0;    seen_next = 1'b0;
            stop_next = 1'b0;        ovf_next = 1'b0;    star_next = 2'd0;
            failed_next = 1'b0;
        end
        if (n == 2'd1)
            res[0].run_last = 1'b1;
        else if (n == 2'd2)
            res[1].run_last = 1'b1;
    end

    assign push_data.count = n;
    assign push_data.res0  = res[0];
    assign push_data.res1  = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= 7'd46;   open_reg <= 7'd91;  close_reg <= 7'd93;
            quote_reg <= 7'd34; wild_reg <= 7'd42;  esc_reg <= 7'd92;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DOT:    dot_reg   <= cfg_data[6:0];
                REG_OPEN:   open_reg  <= cfg_data[6:0];
                REG_CLOSE:  close_reg <= cfg_data[6:0];
                REG_QUOTE:  quote_reg <= cfg_data[6:0];
                REG_WILD:   wild_reg  <= cfg_data[6:0];
                REG_ESCAPE: esc_reg   <= cfg_data[6:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;  first_reg <= 1'b1;  escp_reg <= 1'b0;
            ulft_reg <= 2'd0;       upart_reg <= 21'd0; nonempty_reg <= 1'b0;
            acc_reg <= 64'd0;       neg_reg <= 1'b0;    seen_reg <= 1'b0;
            stop_reg <= 1'b0;       ovf_reg <= 1'b0;    star_reg <= 2'd0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;  first_reg <= first_next;  escp_reg <= escp_next;
            ulft_reg <= ulft_next;    upart_reg <= upart_next;  nonempty_reg <= nonempty_next;
            acc_reg <= acc_next;      neg_reg <= neg_next;      seen_reg <= seen_next;
            stop_reg <= stop_next;    ovf_reg <= ovf_next;      star_reg <= star_next;
            failed_reg <= failed_next;
        end
    end

endmodule

FILE: rtl/core/spt_queue.sv
// ----------------------------------------------------------------------------
// spt_queue
// Short queue of step records between the front and the back.
// ----------------------------------------------------------------------------
module spt_queue
#(
    parameter int DEPTH = spt_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  spt_pkg::step_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output spt_pkg::step_t pop_data
);
    import spt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    step_t          mem [DEPTH];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (do_pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
    end

endmodule

FILE: rtl/core/spt_back.sv
// ----------------------------------------------------------------------------
// spt_back
// Output register: plays out the one or two results of each step record.
// ----------------------------------------------------------------------------
module spt_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  spt_pkg::step_t     pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output spt_pkg::result_t   out_res
);
    import spt_pkg::*;

    step_t cur_reg;
    logic  slot_reg;
    logic  have_reg;
    logic  taken, last_of_step;

    assign out_valid    = have_reg;
    assign out_res      = slot_reg ? cur_reg.res1 : cur_reg.res0;
    assign taken        = out_valid && out_ready;
    assign last_of_step = slot_reg || (cur_reg.count == 2'd1);
    assign pop_ready    = !have_reg || (taken && last_of_step);

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            cur_reg <= pop_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            slot_reg <= 1'b0;
        end
        else if (pop_valid && pop_ready)
        begin
            have_reg <= 1'b1;
            slot_reg <= 1'b0;
        end
        else if (taken)
        begin
            if (last_of_step)
                have_reg <= 1'b0;
            else
                slot_reg <= 1'b1;
        end
    end

endmodule

FILE: rtl/core/subfield_path_tokenizer.sv
// ----------------------------------------------------------------------------
// subfield_path_tokenizer
// Streaming tokenizer for column paths into names and subscripts.
// ----------------------------------------------------------------------------
// One path byte is accepted per cycle while the step queue has room; each byte
// is classified in the cycle it is accepted and yields zero, one or two
// results; any results are queued as one record and played out one result
// per cycle from the output register while results are taken. Sustained
// input rate is one byte per cycle as long as results are taken; a byte
// giving two results needs two transfers out, so a long run of them fills the queue.
// Delimiter registers are written through the cfg channel, which is always
// ready; write them only while the block is idle.
module subfield_path_tokenizer
#(
    parameter int QDEPTH = spt_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    path_byte,
    input  logic                          final_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    result_kind,
    output logic [1:0]                    token_kind,
    output logic [7:0]                    content_byte,
    output logic signed [63:0]            index_value,
    output logic [1:0]                    error_code,
    output logic                          path_end,
    output logic                          run_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import spt_pkg::*;

    logic    push_valid, push_ready, pop_valid, pop_ready;
    step_t   push_data, pop_data;
    result_t res;

    spt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .path_byte  (path_byte),
        .final_byte (final_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    spt_queue #(.DEPTH(QDEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    spt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign result_kind  = res.result_kind;
    assign token_kind   = res.token_kind;
    assign content_byte = res.content_byte;
    assign index_value  = res.index_value;
    assign error_code   = res.error_code;
    assign path_end     = res.path_end;
    assign run_last     = res.run_last;

endmodule

FILE: bench/subfield_path_tokenizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subfield_path_tokenizer_test
// Streams column paths into the tokenizer and checks every result against a
// cycle-free behavioural predictor, across several delimiter settings and
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module subfield_path_tokenizer_test;
    import spt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic [7:0] b;
        logic       f;
    } path_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           path_byte;
    logic                 final_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           result_kind;
    logic [1:0]           token_kind;
    logic [7:0]           content_byte;
    logic signed [63:0]   index_value;
    logic [1:0]           error_code;
    logic                 path_end;
    logic                 run_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    subfield_path_tokenizer dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .path_byte(path_byte), .final_byte(final_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .token_kind(token_kind),
        .content_byte(content_byte), .index_value(index_value),
        .error_code(error_code), .path_end(path_end), .run_last(run_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    path_item_t pending_bytes[$];
    result_t    expected_results[$];
    logic [7:0] path_buf[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         fail_count;
    int         quiet_cycles;
    int         bytes_made;
    bit         in_took;
    bit         cfg_took;

    // predictor copy of the delimiter registers
    logic [6:0] dot_c, open_c, close_c, quote_c, wild_c, esc_c;

    // predictor copy of the parse state
    phase_t      phase;
    bit          first_tok;
    bit          esc_pend;
    int          utf8_left;
    logic [20:0] utf8_point;
    bit          tok_nonempty;
    logic [63:0] idx_acc;
    bit          idx_neg;
    bit          idx_seen;
    bit          idx_stopped;
    bit          idx_ovf;
    int          star_track;
    bit          path_failed;

    result_t step_res[2];
    int      step_cnt;

    function automatic void put_result(logic [1:0] rk, logic [1:0] tk, logic [7:0] cb,
                                       logic [63:0] iv, logic [1:0] ec);
        if (step_cnt < 2)
        begin
            step_res[step_cnt] = '{rk, tk, cb, iv, ec, 1'b0, 1'b0};
            step_cnt++;
        end
    endfunction

    function automatic void raise_error(logic [1:0] ec);
        put_result(RK_ERROR, TK_NESTED, 8'd0, 64'd0, ec);
        path_failed = 1'b1;
    endfunction

    function automatic bit is_delim(logic [7:0] c);
        return c == {1'b0, dot_c} || c == {1'b0, open_c} || c == {1'b0, close_c} ||
               c == {1'b0, quote_c} || c == {1'b0, wild_c};
    endfunction

    function automatic bit is_sub_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "_" || c == "-";
    endfunction

    function automatic bit is_name_char(logic [7:0] c);
        return c == ":" || c == "$" || c == "-" || c == "/" || c == "@" ||
               c == "|" || c == "#" || c == "." || is_sub_char(c);
    endfunction

    function automatic void clear_index();
        tok_nonempty = 1'b0;
        idx_acc = '0;
        idx_neg = 1'b0;
        idx_seen = 1'b0;
        idx_stopped = 1'b0;
        idx_ovf = 1'b0;
    endfunction

    function automatic void clear_path();
        phase = PH_START;
        first_tok = 1'b1;
        esc_pend = 1'b0;
        utf8_left = 0;
        utf8_point = '0;
        clear_index();
        star_track = 0;
        path_failed = 1'b0;
    endfunction

    function automatic void index_take(bit ascii, logic [7:0] c);
        bit          first;
        logic [63:0] d;
        logic [63:0] lim;
        first = !tok_nonempty;
        tok_nonempty = 1'b1;
        if (idx_stopped)
            return;
        if (ascii && c >= "0" && c <= "9")
        begin
            d = 64'(c - "0");
            lim = idx_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            idx_seen = 1'b1;
            if (!idx_ovf)
            begin
                if (idx_acc > (lim - d) / 64'd10)
                    idx_ovf = 1'b1;
                else
                    idx_acc = idx_acc * 64'd10 + d;
            end
        end
        else if (ascii && c == "-" && first)
            idx_neg = 1'b1;
        else
            idx_stopped = 1'b1;
    endfunction

    function automatic void quoted_content(bit ascii, logic [7:0] c);
        star_track = (star_track == 0 && ascii && c == "*") ? 1 : 2;
        put_result(RK_CONTENT, TK_STRING, c, 64'd0, 2'd0);
    endfunction

    // one ASCII character or the lead byte of a multi-byte character
    function automatic void take_char(bit ascii, logic [7:0] c);
        bit done;
        done = 1'b0;
        while (!done)
        begin
            done = 1'b1;
            case (phase)
                PH_START:
                    if (ascii && c == {1'b0, dot_c})
                    begin
                        phase = PH_NAME;
                        tok_nonempty = 1'b0;
                        first_tok = 1'b0;
                    end
                    else if (ascii && c == {1'b0, open_c})
                    begin
                        phase = PH_OPENED;
                        first_tok = 1'b0;
                    end
                    else if (first_tok)
                    begin
                        phase = PH_NAME;
                        tok_nonempty = 1'b0;
                        first_tok = 1'b0;
                        done = 1'b0;
                    end
                    else
                        raise_error(ERR_SYNTAX);
                PH_NAME:
                    if (!ascii || (!is_delim(c) && is_name_char(c)))
                    begin
                        tok_nonempty = 1'b1;
                        put_result(RK_CONTENT, TK_NESTED, c, 64'd0, 2'd0);
                    end
                    else if (!tok_nonempty)
                        raise_error(ERR_SYNTAX);
                    else
                    begin
                        put_result(RK_END, TK_NESTED, 8'd0, 64'd0, 2'd0);
                        phase = PH_START;
                        done = 1'b0;
                    end
                PH_OPENED:
                    if (ascii && c == {1'b0, quote_c})
                    begin
                        phase = PH_QUOTED;
                        star_track = 0;
                        esc_pend = 1'b0;
                    end
                    else if (ascii && c == {1'b0, wild_c})
                        phase = PH_CLOSE_ALL;
                    else
                    begin
                        phase = PH_UNQUOTED;
                        clear_index();
                        done = 1'b0;
                    end
                PH_UNQUOTED:
                    if (!ascii || is_sub_char(c))
                        index_take(ascii, c);
                    else if (!tok_nonempty)
                        raise_error(ERR_SYNTAX);
                    else if (!idx_seen || idx_ovf)
                        raise_error(ERR_INDEX);
                    else if (c == {1'b0, close_c})
                    begin
                        put_result(RK_END, TK_INDEX, 8'd0,
                                   idx_neg ? 64'd0 - idx_acc : idx_acc, 2'd0);
                        phase = PH_START;
                    end
                    else
                        raise_error(ERR_SYNTAX);
                PH_QUOTED:
                    if (esc_pend)
                    begin
                        esc_pend = 1'b0;
                        if (ascii && (c == {1'b0, quote_c} || c == {1'b0, esc_c}))
                            quoted_content(ascii, c);
                        else
                            raise_error(ERR_SYNTAX);
                    end
                    else if (ascii && c == {1'b0, esc_c})
                        esc_pend = 1'b1;
                    else if (ascii && c == {1'b0, quote_c})
                        phase = (star_track == 1) ? PH_CLOSE_ALL : PH_CLOSE_STR;
                    else
                        quoted_content(ascii, c);
                PH_CLOSE_STR, PH_CLOSE_ALL:
                    if (ascii && c == {1'b0, close_c})
                    begin
                        put_result(RK_END, phase == PH_CLOSE_ALL ? TK_ALL : TK_STRING,
                                   8'd0, 64'd0, 2'd0);
                        phase = PH_START;
                    end
                    else
                        raise_error(ERR_SYNTAX);
                default:
                    raise_error(ERR_SYNTAX);
            endcase
        end
    endfunction

    function automatic void predict_step(logic [7:0] b, logic fin);
        bit          ok;
        logic [20:0] p;
        step_cnt = 0;
        if (!path_failed)
        begin
            if (utf8_left > 0)
            begin
                ok = (b & 8'hC0) == 8'h80;
                p = utf8_point;
                if (ok && utf8_left == 3)
                begin
                    if ((p == 0 && b < 8'h90) || (p == 4 && b > 8'h8F))
                        ok = 1'b0;
                end
                else if (ok && utf8_left == 2 && p < 21'h10)
                begin
                    if ((p == 0 && b < 8'hA0) || (p == 21'hD && b > 8'h9F))
                        ok = 1'b0;
                end
                if (!ok)
                    raise_error(ERR_UTF8);
                else
                begin
                    utf8_point = (p << 6) | 21'(b & 8'h3F);
                    utf8_left--;
                    if (phase == PH_NAME)
                        put_result(RK_CONTENT, TK_NESTED, b, 64'd0, 2'd0);
                    else if (phase == PH_QUOTED)
                    begin
                        star_track = 2;
                        put_result(RK_CONTENT, TK_STRING, b, 64'd0, 2'd0);
                    end
                end
            end
            else if (b < 8'h80)
                take_char(1'b1, b);
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                utf8_left = 1;
                utf8_point = 21'(b & 8'h1F);
                take_char(1'b0, b);
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                utf8_left = 2;
                utf8_point = 21'(b & 8'h0F);
                take_char(1'b0, b);
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                utf8_left = 3;
                utf8_point = 21'(b & 8'h07);
                take_char(1'b0, b);
            end
            else
                raise_error(ERR_UTF8);
        end
        if (fin)
        begin
            if (!path_failed)
            begin
                if (utf8_left > 0)
                    raise_error(ERR_UTF8);
                else if (phase == PH_NAME)
                begin
                    if (tok_nonempty)
                        put_result(RK_END, TK_NESTED, 8'd0, 64'd0, 2'd0);
                    else
                        raise_error(ERR_UNTERM);
                end
                else if (phase == PH_UNQUOTED)
                begin
                    if (tok_nonempty && (!idx_seen || idx_ovf))
                        raise_error(ERR_INDEX);
                    else
                        raise_error(ERR_UNTERM);
                end
                else if (phase == PH_START)
                begin
                    if (step_cnt == 0)
                        raise_error(ERR_UNTERM);
                end
                else
                    raise_error(ERR_UNTERM);
            end
            if (step_cnt > 0)
                step_res[step_cnt-1].path_end = 1'b1;
            clear_path();
        end
        if (step_cnt > 0)
            step_res[step_cnt-1].run_last = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            expected_results.push_back(step_res[i]);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t exp_r;
        in_took = in_valid && in_ready;
        cfg_took = cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (in_took)
                predict_step(path_byte, final_byte);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d", result_kind);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result_kind !== exp_r.result_kind)
                    begin
                        $error("result_kind expected %0d got %0d",
                               exp_r.result_kind, result_kind);
                        fail_count++;
                    end
                    if (token_kind !== exp_r.token_kind)
                    begin
                        $error("token_kind expected %0d got %0d",
                               exp_r.token_kind, token_kind);
                        fail_count++;
                    end
                    if (content_byte !== exp_r.content_byte)
                    begin
                        $error("content_byte expected %0h got %0h",
                               exp_r.content_byte, content_byte);
                        fail_count++;
                    end
                    if (index_value !== exp_r.index_value)
                    begin
                        $error("index_value expected %0d got %0d",
                               exp_r.index_value, index_value);
                        fail_count++;
                    end
                    if (error_code !== exp_r.error_code)
                    begin
                        $error("error_code expected %0d got %0d",
                               exp_r.error_code, error_code);
                        fail_count++;
                    end
                    if (path_end !== exp_r.path_end)
                    begin
                        $error("path_end expected %0d got %0d", exp_r.path_end, path_end);
                        fail_count++;
                    end
                    if (run_last !== exp_r.run_last)
                    begin
                        $error("run_last expected %0d got %0d", exp_r.run_last, run_last);
                        fail_count++;
                    end
                end
            end
            if (in_took || cfg_took || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("subfield_path_tokenizer test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: path bytes in, ready out, both at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        path_item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_took)
                ; // hold the transaction until it is taken
            else if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_bytes.pop_front();
                path_byte <= it.b;
                final_byte <= it.f;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_took);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DOT:    dot_c = data[6:0];
            REG_OPEN:   open_c = data[6:0];
            REG_CLOSE:  close_c = data[6:0];
            REG_QUOTE:  quote_c = data[6:0];
            REG_WILD:   wild_c = data[6:0];
            REG_ESCAPE: esc_c = data[6:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            path_buf.push_back(s[i]);
    endfunction

    function automatic void flush_path();
        for (int i = 0; i < path_buf.size(); i++)
            pending_bytes.push_back('{path_buf[i], i == path_buf.size() - 1});
        bytes_made += path_buf.size();
        path_buf.delete();
    endfunction

    function automatic void add_utf8();
        int cp;
        case ($urandom_range(4))
            0: cp = $urandom_range(16'h80, 16'h7FF);
            1:
            begin
                cp = $urandom_range(16'h800, 16'hFFFF);
                if (cp >= 16'hD800 && cp <= 16'hDFFF)
                    cp = 16'hE000;
            end
            2: cp = $urandom_range(32'h10000, 32'h10FFFF);
            default: cp = -1;
        endcase
        if (cp < 0)
        begin
            // malformed forms: bad lead, stray continuation, overlong, surrogate, too high, truncated
            case ($urandom_range(6))
                0: path_buf.push_back(8'(($urandom_range(1) == 0) ? 8'hC0 + $urandom_range(1)
                                                                  : 8'hF5 + $urandom_range(10)));
                1: path_buf.push_back(8'(8'h80 + $urandom_range(63)));
                2: begin path_buf.push_back(8'hE0); path_buf.push_back(8'h9F); end
                3: begin path_buf.push_back(8'hED); path_buf.push_back(8'hA0); end
                4: begin path_buf.push_back(8'hF4); path_buf.push_back(8'h90); end
                5: begin path_buf.push_back(8'hF0); path_buf.push_back(8'h8F); end
                default: begin path_buf.push_back(8'hC3); path_buf.push_back("a"); end
            endcase
        end
        else if (cp < 16'h800)
        begin
            path_buf.push_back(8'(8'hC0 | (cp >> 6)));
            path_buf.push_back(8'(8'h80 | (cp & 6'h3F)));
        end
        else if (cp < 32'h10000)
        begin
            path_buf.push_back(8'(8'hE0 | (cp >> 12)));
            path_buf.push_back(8'(8'h80 | ((cp >> 6) & 6'h3F)));
            path_buf.push_back(8'(8'h80 | (cp & 6'h3F)));
        end
        else
        begin
            path_buf.push_back(8'(8'hF0 | (cp >> 18)));
            path_buf.push_back(8'(8'h80 | ((cp >> 12) & 6'h3F)));
            path_buf.push_back(8'(8'h80 | ((cp >> 6) & 6'h3F)));
            path_buf.push_back(8'(8'h80 | (cp & 6'h3F)));
        end
    endfunction

    function automatic void make_path();
        string pool;
        int    ntok;
        int    n;
        int    pos;
        pool = "abzAMZ059_:$-/@|#~ ";
        ntok = $urandom_range(1, 4);
        for (int t = 0; t < ntok; t++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    if (t > 0 || $urandom_range(1))
                        path_buf.push_back({1'b0, dot_c});
                    n = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        if ($urandom_range(6) == 0)
                            add_utf8();
                        else
                            path_buf.push_back(pool[$urandom_range(pool.len() - 1)]);
                end
                4, 5:
                begin
                    path_buf.push_back({1'b0, open_c});
                    if ($urandom_range(2) == 0)
                        path_buf.push_back("-");
                    case ($urandom_range(7))
                        0: push_str("9223372036854775807");
                        1: push_str("9223372036854775808");
                        2: for (int i = 0; i < 20; i++) path_buf.push_back(8'("0" + $urandom_range(9)));
                        3: ;
                        default:
                            for (int i = $urandom_range(1, 4); i > 0; i--)
                                path_buf.push_back(8'("0" + $urandom_range(9)));
                    endcase
                    if ($urandom_range(7) == 0)
                        push_str("x-9");
                    if ($urandom_range(15) == 0)
                        add_utf8();
                    path_buf.push_back({1'b0, close_c});
                end
                6, 7:
                begin
                    path_buf.push_back({1'b0, open_c});
                    path_buf.push_back({1'b0, quote_c});
                    if ($urandom_range(4) == 0)
                        path_buf.push_back("*");
                    else
                        for (int i = $urandom_range(0, 5); i > 0; i--)
                            case ($urandom_range(5))
                                0:
                                begin
                                    path_buf.push_back({1'b0, esc_c});
                                    case ($urandom_range(4))
                                        0: path_buf.push_back("q");
                                        1, 2: path_buf.push_back({1'b0, quote_c});
                                        default: path_buf.push_back({1'b0, esc_c});
                                    endcase
                                end
                                1: add_utf8();
                                default: path_buf.push_back(pool[$urandom_range(pool.len() - 1)]);
                            endcase
                    path_buf.push_back({1'b0, quote_c});
                    path_buf.push_back({1'b0, close_c});
                end
                default:
                begin
                    path_buf.push_back({1'b0, open_c});
                    path_buf.push_back({1'b0, wild_c});
                    path_buf.push_back({1'b0, close_c});
                end
            endcase
        end
        // break a share of the paths: corrupt, cut short or splice in noise
        if (path_buf.size() == 0)
            path_buf.push_back(8'($urandom_range(255)));
        pos = $urandom_range(path_buf.size() - 1);
        case ($urandom_range(11))
            0: path_buf[pos] = 8'($urandom_range(255));
            1: while (path_buf.size() > pos + 1) void'(path_buf.pop_back());
            2: path_buf.insert(pos, 8'($urandom_range(255)));
            default: ;
        endcase
        flush_path();
    endfunction

    task automatic run_batch(int n_bytes);
        int goal;
        goal = bytes_made + n_bytes / 2;
        while (bytes_made < goal)
            make_path();
        // pause the sender until everything sent so far has come out
        drain();
        goal = bytes_made + n_bytes / 2;
        while (bytes_made < goal)
            make_path();
        drain();
    endtask

    task automatic run_phase(int n_bytes);
        send_idle_pct = 0;  recv_stall_pct = 0;  run_batch(n_bytes);
        send_idle_pct = 61; recv_stall_pct = 0;  run_batch(n_bytes);
        send_idle_pct = 0;  recv_stall_pct = 61; run_batch(n_bytes);
        send_idle_pct = 30; recv_stall_pct = 30; run_batch(n_bytes);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        path_byte = 8'd0;
        final_byte = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = 8'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        quiet_cycles = 0;
        bytes_made = 0;
        dot_c = 7'd46;
        open_c = 7'd91;
        close_c = 7'd93;
        quote_c = 7'd34;
        wild_c = 7'd42;
        esc_c = 7'd92;
        clear_path();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: the worked example, a quoted lone star, a bad lead byte
        push_str("a.b[3][\"k\\\"x\"][*]");
        flush_path();
        push_str("[\"*\"]");
        flush_path();
        path_buf.push_back(8'hFF);
        flush_path();
        drain();

        // each half batch runs over its goal by part of a path
        run_phase(96);

        // top bit of the write data is dropped by the register
        write_reg(REG_DOT, 8'hAF);
        write_reg(REG_OPEN, "(");
        write_reg(REG_CLOSE, ")");
        write_reg(REG_QUOTE, 8'h27);
        write_reg(REG_WILD, "?");
        write_reg(REG_ESCAPE, "!");
        run_phase(96);

        write_reg(REG_DOT, 8'h00);
        write_reg(REG_OPEN, 8'h7F);
        write_reg(REG_CLOSE, 8'h80);
        write_reg(REG_QUOTE, 8'hFF);
        write_reg(REG_WILD, 8'h01);
        write_reg(REG_ESCAPE, 8'h7E);
        run_phase(96);

        write_reg(REG_DOT, 8'd46);
        write_reg(REG_OPEN, 8'd91);
        write_reg(REG_CLOSE, 8'd93);
        write_reg(REG_QUOTE, 8'd34);
        write_reg(REG_WILD, 8'd42);
        write_reg(REG_ESCAPE, 8'd92);
        run_phase(96);

        drain();
        if (fail_count == 0)
            $display("subfield_path_tokenizer test passed");
        else
            $display("subfield_path_tokenizer test failed");
        $finish;
    end

endmodule
